### sv/ppc_pkg.sv
// ----------------------------------------------------------------------------
// ppc_pkg
// Shared types and constants for the prime and palindrome checker.
// ----------------------------------------------------------------------------
package ppc_pkg;

  localparam int unsigned RADIX       = 10;
  localparam int unsigned FIRST_PRIME = 2;
  localparam int unsigned FIRST_ODD   = 3;
  localparam int unsigned ODD_STEP    = 2;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage
// ----------------------------------------------------------------------------

### sv/prime_palindrome_check.sv
// ----------------------------------------------------------------------------
// prime_palindrome_check
// Reports whether a signed value is a decimal palindrome, prime, or both.
// ----------------------------------------------------------------------------
// Usage:
//   in_value is taken on a transfer (in_valid high, in_stall low). Only the
//   low VALUE_WIDTH bits count, read as two's complement; negative values
//   give all flags low. in_stall stays high while an item is being worked.
//   The palindrome pass splits the value into decimal digits, one division
//   by ten per digit, and rebuilds the reversed number. The prime pass tests
//   the low bit for a factor of 2 and does trial division by odd d while
//   d*d <= value, the square kept up by adds. Every division runs on one
//   shared divider. The worst case is near 23200 divisions at width 32.
//   Negative values skip both passes and go straight to the finish state.
//   Results sit in an output register until a transfer on out_ (out_valid
//   high, out_stall low); a new item is taken meanwhile, and a finished
//   item waits while out_stall holds the previous one.
//   Reset clears the sequencer and out_valid.
// ----------------------------------------------------------------------------
module prime_palindrome_check #(
  parameter int VALUE_WIDTH = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [31:0] in_value,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_palindrome_flag,
  output logic        out_prime_flag,
  output logic        out_both_flag
);

  localparam int MW = VALUE_WIDTH - 1;
  localparam int RW = MW + 4;
  localparam int DW = MW / 2 + 2;
  localparam int SW = MW + 2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PAL,
    ST_PAL_WAIT,
    ST_PRI_INIT,
    ST_PRI_CHK,
    ST_PRI_WAIT,
    ST_FINISH
  } state_t;

  state_t        state_r, state_nxt;
  logic [MW-1:0] val_r, val_nxt;
  logic [MW-1:0] cur_r, cur_nxt;
  logic [RW-1:0] rev_r, rev_nxt;
  logic [DW-1:0] d_r, d_nxt;
  logic [SW-1:0] sq_r, sq_nxt;
  logic          pal_r, pal_nxt;
  logic          pri_r, pri_nxt;
  logic          out_valid_r, out_valid_nxt;
  logic          out_pal_r, out_pal_nxt;
  logic          out_pri_r, out_pri_nxt;
  logic          out_both_r, out_both_nxt;

  logic               in_fire;
  logic               out_free;
  logic               div_start;
  logic [MW-1:0]      div_dividend;
  logic [MW-1:0]      div_divisor;
  logic [MW-1:0]      div_quotient;
  logic [MW-1:0]      div_remainder;
  ppc_pkg::div_stat_t div_stat;

  assign in_stall = (state_r != ST_IDLE);
  assign in_fire  = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;

  ppc_div #(
    .WIDTH (MW)
  ) u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (div_start),
    .dividend  (div_dividend),
    .divisor   (div_divisor),
    .quotient  (div_quotient),
    .remainder (div_remainder),
    .stat      (div_stat)
  );

  always_comb begin
    state_nxt     = state_r;
    val_nxt       = val_r;
    cur_nxt       = cur_r;
    rev_nxt       = rev_r;
    d_nxt         = d_r;
    sq_nxt        = sq_r;
    pal_nxt       = pal_r;
    pri_nxt       = pri_r;
    out_valid_nxt = out_valid_r;
    out_pal_nxt   = out_pal_r;
    out_pri_nxt   = out_pri_r;
    out_both_nxt  = out_both_r;
    div_start     = 1'b0;
    div_dividend  = cur_r;
    div_divisor   = MW'(ppc_pkg::RADIX);

    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          if (in_value[VALUE_WIDTH-1]) begin
            pal_nxt   = 1'b0;
            pri_nxt   = 1'b0;
            state_nxt = ST_FINISH;
          end else begin
            val_nxt   = in_value[MW-1:0];
            cur_nxt   = in_value[MW-1:0];
            rev_nxt   = '0;
            state_nxt = ST_PAL;
          end
        end
      end
      ST_PAL: begin
        if (cur_r == '0) begin
          pal_nxt   = (rev_r == RW'(val_r));
          state_nxt = ST_PRI_INIT;
        end else begin
          div_start = 1'b1;
          state_nxt = ST_PAL_WAIT;
        end
      end
      ST_PAL_WAIT: begin
        if (div_stat.done) begin
          cur_nxt   = div_quotient;
          rev_nxt   = (rev_r << 3) + (rev_r << 1) + RW'(div_remainder[3:0]);
          state_nxt = ST_PAL;
        end
      end
      ST_PRI_INIT: begin
        if (val_r < MW'(ppc_pkg::FIRST_PRIME)) begin
          pri_nxt   = 1'b0;
          state_nxt = ST_FINISH;
        end else if (val_r == MW'(ppc_pkg::FIRST_PRIME)) begin
          pri_nxt   = 1'b1;
          state_nxt = ST_FINISH;
        end else if (!val_r[0]) begin
          pri_nxt   = 1'b0;
          state_nxt = ST_FINISH;
        end else begin
          d_nxt     = DW'(ppc_pkg::FIRST_ODD);
          sq_nxt    = SW'(ppc_pkg::FIRST_ODD * ppc_pkg::FIRST_ODD);
          state_nxt = ST_PRI_CHK;
        end
      end
      ST_PRI_CHK: begin
        if (sq_r > SW'(val_r)) begin
          pri_nxt   = 1'b1;
          state_nxt = ST_FINISH;
        end else begin
          div_start    = 1'b1;
          div_dividend = val_r;
          div_divisor  = MW'(d_r);
          state_nxt    = ST_PRI_WAIT;
        end
      end
      ST_PRI_WAIT: begin
        if (div_stat.done) begin
          if (div_remainder == '0) begin
            pri_nxt   = 1'b0;
            state_nxt = ST_FINISH;
          end else begin
            // (d+2)^2 = d^2 + 4d + 4
            sq_nxt    = sq_r + SW'({d_r, 2'b00}) + SW'(2 * ppc_pkg::ODD_STEP);
            d_nxt     = d_r + DW'(ppc_pkg::ODD_STEP);
            state_nxt = ST_PRI_CHK;
          end
        end
      end
      ST_FINISH: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_pal_nxt   = pal_r;
          out_pri_nxt   = pri_r;
          out_both_nxt  = pal_r && pri_r;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      val_r       <= val_nxt;
      cur_r       <= cur_nxt;
      rev_r       <= rev_nxt;
      d_r         <= d_nxt;
      sq_r        <= sq_nxt;
      pal_r       <= pal_nxt;
      pri_r       <= pri_nxt;
      out_pal_r   <= out_pal_nxt;
      out_pri_r   <= out_pri_nxt;
      out_both_r  <= out_both_nxt;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_palindrome_flag = out_pal_r;
  assign out_prime_flag      = out_pri_r;
  assign out_both_flag       = out_both_r;

  a_div_idle_on_start: assert property (@(posedge clk) disable iff (!rst_n)
    div_start |-> !div_stat.busy)
    else $error("divider started while busy");

  a_negative_short: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && in_value[VALUE_WIDTH-1] |=> state_r == ST_FINISH && !pal_r && !pri_r)
    else $error("negative value not short-cut");

  a_both_consistent: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> out_both_r == (out_pal_r && out_pri_r))
    else $error("both flag inconsistent");

endmodule
// ----------------------------------------------------------------------------

### sv/ppc_div.sv
// ----------------------------------------------------------------------------
// ppc_div
// Restoring radix-2 divider, one quotient bit per cycle, shared by the
// digit split and the trial division.
// ----------------------------------------------------------------------------
module ppc_div #(
  parameter int WIDTH = 31
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  logic [WIDTH-1:0]    dividend,
  input  logic [WIDTH-1:0]    divisor,
  output logic [WIDTH-1:0]    quotient,
  output logic [WIDTH-1:0]    remainder,
  output ppc_pkg::div_stat_t  stat
);

  localparam int CW = $clog2(WIDTH + 1);

  logic             busy_r;
  logic             done_r;
  logic [CW-1:0]    cnt_r;
  logic [WIDTH-1:0] quo_r;
  logic [WIDTH-1:0] rem_r;
  logic [WIDTH-1:0] dvs_r;
  logic [WIDTH:0]   shifted;
  logic [WIDTH:0]   diff;
  logic             fits;

  always_comb begin
    shifted = {rem_r, quo_r[WIDTH-1]};
    fits    = shifted >= {1'b0, dvs_r};
    diff    = shifted - {1'b0, dvs_r};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CW'(WIDTH);
        quo_r  <= dividend;
        rem_r  <= '0;
        dvs_r  <= divisor;
      end else if (busy_r) begin
        if (fits) begin
          rem_r <= diff[WIDTH-1:0];
          quo_r <= {quo_r[WIDTH-2:0], 1'b1};
        end else begin
          rem_r <= shifted[WIDTH-1:0];
          quo_r <= {quo_r[WIDTH-2:0], 1'b0};
        end
        cnt_r <= cnt_r - CW'(1);
        if (cnt_r == CW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign quotient  = quo_r;
  assign remainder = rem_r;
  assign stat.busy = busy_r;
  assign stat.done = done_r;

  a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start |=> busy_r)
    else $error("divider not busy after start");

  a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> $past(busy_r) && !busy_r)
    else $error("divider done without a finished run");

endmodule
// ----------------------------------------------------------------------------
